// File: hw/rtl/stereo_led_bar_level_meter_core_defines.svh
// ----------------------------------------------------------------------------
// Stereo LED bar level meter - assertion macros
// Shared property wrappers; clocked on i_clk, off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEREO_LED_BAR_LEVEL_METER_CORE_DEFINES_SVH
`define STEREO_LED_BAR_LEVEL_METER_CORE_DEFINES_SVH

// Same-cycle implication
`define SLBM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slbm check failed");

// Next-cycle implication
`define SLBM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slbm check failed");

`endif

// File: hw/rtl/slbm_pkg.sv
// ----------------------------------------------------------------------------
// slbm_pkg
// Widths, register indexes, level table and shared types of the level meter.
// ----------------------------------------------------------------------------
package slbm_pkg;

    localparam int LEVEL_W     = 15;
    localparam int LIT_W       = 4;
    localparam int ICON_W      = 3;
    localparam int DECAY_W     = 3;
    localparam int IDX_W       = 6;
    localparam int NUM_W       = 7;
    localparam int DEN_W       = 4;
    localparam int CNT_W       = 3;
    localparam int MUL_W       = LEVEL_W + IDX_W;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [IDX_W-1:0] DB_STEPS   = 6'd44;
    localparam logic [IDX_W-1:0] LED_COUNT  = 6'd11;
    localparam logic [LIT_W-1:0] LIT_MAX    = 4'd11;

    // Register indexes (word address bit 2)
    localparam logic REG_USE_DB = 1'b0;
    localparam logic REG_DECAY  = 1'b1;

    // Request into the shared divide unit
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    // Answer from the shared divide unit
    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

    // Logarithmic segment table, 44 steps
    function automatic logic [LIT_W-1:0] db_lookup(input logic [IDX_W-1:0] idx);
        logic [LIT_W-1:0] seg;
        if (idx == 6'd0)       seg = 4'd0;
        else if (idx == 6'd1)  seg = 4'd2;
        else if (idx == 6'd2)  seg = 4'd3;
        else if (idx <= 6'd4)  seg = 4'd5;
        else if (idx <= 6'd7)  seg = 4'd6;
        else if (idx <= 6'd11) seg = 4'd7;
        else if (idx <= 6'd16) seg = 4'd8;
        else if (idx <= 6'd24) seg = 4'd9;
        else if (idx <= 6'd35) seg = 4'd10;
        else                   seg = 4'd11;
        return seg;
    endfunction

    // Count thresholds 1, 2, 5, 8 lying below the lit count
    function automatic logic [ICON_W-1:0] icon_level(input logic [LIT_W-1:0] lit);
        return ICON_W'(lit > 4'd1) + ICON_W'(lit > 4'd2) +
               ICON_W'(lit > 4'd5) + ICON_W'(lit > 4'd8);
    endfunction

endpackage

// File: hw/rtl/slbm_if.sv
// ----------------------------------------------------------------------------
// slbm_in_if / slbm_out_if
// Valid/ready channels carrying peak items in and meter items out.
// ----------------------------------------------------------------------------
interface slbm_in_if;
    logic                            valid;
    logic                            ready;
    logic [slbm_pkg::LEVEL_W-1:0]    left_level;
    logic [slbm_pkg::LEVEL_W-1:0]    right_level;

    modport source (output valid, output left_level, output right_level, input ready);
    modport sink   (input valid, input left_level, input right_level, output ready);
endinterface

interface slbm_out_if;
    logic                            valid;
    logic                            ready;
    logic [slbm_pkg::LIT_W-1:0]      left_lit;
    logic [slbm_pkg::LIT_W-1:0]      right_lit;
    logic [slbm_pkg::ICON_W-1:0]     left_icon;
    logic [slbm_pkg::ICON_W-1:0]     right_icon;

    modport source (output valid, output left_lit, output right_lit,
                    output left_icon, output right_icon, input ready);
    modport sink   (input valid, input left_lit, input right_lit,
                    input left_icon, input right_icon, output ready);
endinterface

// File: hw/rtl/slbm_div.sv
// ----------------------------------------------------------------------------
// slbm_div
// Shared restoring divider: one quotient bit per cycle, NUM_W quotient bits per job.
// ----------------------------------------------------------------------------
module slbm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  slbm_pkg::t_div_req  i_req,
    output slbm_pkg::t_div_rsp  o_rsp
);
    import slbm_pkg::*;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] n_rem;

    // Shift in the next numerator bit and try the subtract
    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        fits  = (trial >= {1'b0, r_den});
        n_rem = fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.den;
            r_quo <= i_req.num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

// File: hw/rtl/slbm_ctrl.sv
// ----------------------------------------------------------------------------
// slbm_ctrl
// Sequencer: per channel map the peak to a raw count, then smooth it through
// the shared divider; left first, right second.
// ----------------------------------------------------------------------------
module slbm_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [slbm_pkg::LEVEL_W-1:0]     i_left_level,
    input  logic [slbm_pkg::LEVEL_W-1:0]     i_right_level,
    input  logic                             i_use_db,
    input  logic [slbm_pkg::DECAY_W-1:0]     i_decay,
    output slbm_pkg::t_div_req               o_div_req,
    input  slbm_pkg::t_div_rsp               i_div_rsp,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output logic [slbm_pkg::LIT_W-1:0]       o_left_lit,
    output logic [slbm_pkg::LIT_W-1:0]       o_right_lit
);
    import slbm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_NUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic               r_ch;
    logic [LEVEL_W-1:0] r_left_level;
    logic [LEVEL_W-1:0] r_right_level;
    logic [IDX_W-1:0]   r_idx;
    logic [LIT_W-1:0]   r_prev_l;
    logic [LIT_W-1:0]   r_prev_r;

    logic [LEVEL_W-1:0] level;
    logic [MUL_W-1:0]   prod;
    logic [LIT_W-1:0]   raw;
    logic [LIT_W-1:0]   prev;
    logic [LIT_W-1:0]   lit;

    // Scale the peak: 44 steps for the table, 11 for linear
    always_comb begin
        level = r_ch ? r_right_level : r_left_level;
        prod  = MUL_W'(level) * MUL_W'(i_use_db ? DB_STEPS : LED_COUNT);
    end

    // Raw count, weighted sum and divisor for the divider
    always_comb begin
        raw  = i_use_db ? db_lookup((r_idx >= DB_STEPS) ? DB_STEPS - 1'b1 : r_idx)
                        : r_idx[LIT_W-1:0];
        prev = r_ch ? r_prev_r : r_prev_l;
        o_div_req.start = (r_state == ST_NUM);
        o_div_req.num   = NUM_W'(raw) + NUM_W'(prev) * NUM_W'(i_decay);
        o_div_req.den   = DEN_W'(i_decay) + 1'b1;
    end

    // Clamp the smoothed count
    assign lit = (i_div_rsp.quot > NUM_W'(LIT_MAX)) ? LIT_MAX
                                                     : i_div_rsp.quot[LIT_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_MUL;
            ST_MUL:  n_state = ST_NUM;
            ST_NUM:  n_state = ST_DIV;
            ST_DIV: begin
                if (i_div_rsp.done) n_state = r_ch ? ST_FIN : ST_MUL;
            end
            ST_FIN:  if (i_res_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control and channel history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ch     <= 1'b0;
            r_prev_l <= '0;
            r_prev_r <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_ch <= 1'b0;
            end
            if (r_state == ST_DIV && i_div_rsp.done) begin
                if (r_ch) begin
                    r_prev_r <= lit;
                end else begin
                    r_prev_l <= lit;
                    r_ch     <= 1'b1;
                end
            end
        end
    end

    // Capture the item and the scaled index
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_left_level  <= i_left_level;
            r_right_level <= i_right_level;
        end
        if (r_state == ST_MUL) begin
            r_idx <= prod[MUL_W-1:LEVEL_W];
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_FIN);
    assign o_left_lit  = r_prev_l;
    assign o_right_lit = r_prev_r;

endmodule

// File: hw/rtl/stereo_led_bar_level_meter_core.sv
// ----------------------------------------------------------------------------
// stereo_led_bar_level_meter_core
// Stereo LED bar meter: peaks in, smoothed lit counts and icon levels out.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item of left/right peak magnitudes (15 bits each); o_out
//   returns one item per input: lit segment counts 0..11 and icon levels 0..4.
//   Both are valid/ready channels; an item moves when valid and ready are high.
//   APB port: register 0 (addr 0x0) selects dB table (1) or linear (0),
//   register 1 (addr 0x4) holds the decay weight. pready is always high.
//   The core takes no new item until the result is loaded into the output
//   register, so items do not overlap.
//   The shared bit-serial divider runs 7 steps per channel for the
//   smoothing, left then right.
//   A finished item sits in the output register; while the receiver stalls
//   the core still takes and processes one more item, then holds it until
//   the output register frees up.
//   Reset clears the history to zero, dB mode on, decay zero, output empty.
// ----------------------------------------------------------------------------
module stereo_led_bar_level_meter_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    slbm_in_if.sink                               i_in,
    slbm_out_if.source                            o_out,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [slbm_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [slbm_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [slbm_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import slbm_pkg::*;

    logic               r_use_db;
    logic [DECAY_W-1:0] r_decay;
    logic               r_out_valid;
    logic [LIT_W-1:0]   r_left_lit;
    logic [LIT_W-1:0]   r_right_lit;
    logic [ICON_W-1:0]  r_left_icon;
    logic [ICON_W-1:0]  r_right_icon;

    logic               reg_idx;
    logic               res_valid;
    logic               res_ready;
    logic [LIT_W-1:0]   res_left_lit;
    logic [LIT_W-1:0]   res_right_lit;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_db <= 1'b1;
            r_decay  <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_USE_DB: r_use_db <= pwdata[0];
                REG_DECAY:  r_decay  <= pwdata[DECAY_W-1:0];
                default:    r_decay  <= r_decay;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            REG_USE_DB: prdata = APB_DATA_W'(r_use_db);
            REG_DECAY:  prdata = APB_DATA_W'(r_decay);
            default:    prdata = '0;
        endcase
    end

    slbm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .o_in_ready    (i_in.ready),
        .i_left_level  (i_in.left_level),
        .i_right_level (i_in.right_level),
        .i_use_db      (r_use_db),
        .i_decay       (r_decay),
        .o_div_req     (div_req),
        .i_div_rsp     (div_rsp),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_left_lit    (res_left_lit),
        .o_right_lit   (res_right_lit)
    );

    slbm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Output register: load when empty or draining
    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_left_lit   <= res_left_lit;
            r_right_lit  <= res_right_lit;
            r_left_icon  <= icon_level(res_left_lit);
            r_right_icon <= icon_level(res_right_lit);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.left_lit   = r_left_lit;
    assign o_out.right_lit  = r_right_lit;
    assign o_out.left_icon  = r_left_icon;
    assign o_out.right_icon = r_right_icon;

endmodule

// File: hw/rtl/slbm_chk.sv
// ----------------------------------------------------------------------------
// slbm_chk
// Port-level checks of the level meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "stereo_led_bar_level_meter_core_defines.svh"

module slbm_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [slbm_pkg::LIT_W-1:0]     i_left_lit,
    input logic [slbm_pkg::LIT_W-1:0]     i_right_lit,
    input logic [slbm_pkg::ICON_W-1:0]    i_left_icon,
    input logic [slbm_pkg::ICON_W-1:0]    i_right_icon
);
    import slbm_pkg::*;

    // Stalled item holds
    `SLBM_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_left_lit) && $stable(i_right_lit) && $stable(i_left_icon) && $stable(i_right_icon))

    // Core is busy right after taking an item
    `SLBM_ASSERT_NXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

    // Left count in range and icon matches it
    `SLBM_ASSERT_IMP(a_left_icon, i_out_valid, (i_left_lit <= LIT_MAX) && (i_left_icon == icon_level(i_left_lit)))

    // Right count in range and icon matches it
    `SLBM_ASSERT_IMP(a_right_icon, i_out_valid, (i_right_lit <= LIT_MAX) && (i_right_icon == icon_level(i_right_lit)))

endmodule

bind stereo_led_bar_level_meter_core slbm_chk u_slbm_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_left_lit   (o_out.left_lit),
    .i_right_lit  (o_out.right_lit),
    .i_left_icon  (o_out.left_icon),
    .i_right_icon (o_out.right_icon)
);
